>>> src/vlfw_pkg.sv
// ----------------------------------------------------------------------------
// vlfw_pkg
// Shared types and constants for the visual-loss failsafe watchdog.
// ----------------------------------------------------------------------------
package vlfw_pkg;

    // Default width of the time stamps
    localparam int unsigned TIME_BITS_DEF = 48;

    // Rate limits and unit conversion
    localparam int unsigned NOTICE_GAP_US = 50000;
    localparam int unsigned LAND_GAP_US   = 1000000;
    localparam int unsigned US_PER_MS     = 1000;

    // Configuration limits and reset values (milliseconds)
    localparam int unsigned MIN_POSE_AGE_MS     = 50;
    localparam int unsigned MIN_LOSS_TIMEOUT_MS = 100;
    localparam int unsigned RST_POSE_AGE_MS     = 200;
    localparam int unsigned RST_LOSS_TIMEOUT_MS = 1000;

    // Configuration port geometry
    localparam int unsigned CFG_IDX_BITS  = 2;
    localparam int unsigned CFG_DATA_BITS = 16;
    // Largest ms value times 1000 fits in this many bits
    localparam int unsigned US_LIMIT_BITS = 26;

    // Register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_REQUIRE_VISUAL  = 2'd0,
        REG_POSE_MAX_AGE_MS = 2'd1,
        REG_LOSS_TIMEOUT_MS = 2'd2
    } t_cfg_reg;

    // Cached flight mode flags
    typedef struct packed {
        logic landing;
        logic offboard;
        logic armed;
    } t_mode_flags;

endpackage

>>> src/visual_loss_failsafe_watchdog.sv
// ----------------------------------------------------------------------------
// visual_loss_failsafe_watchdog
// Watches visual pose freshness while armed in offboard mode, latches a
// failsafe on a long loss and rate-limits land requests and loss notices.
// ----------------------------------------------------------------------------
// Pipeline: an accepted input beat goes through the input register, then the
// safety decision into the result register.
// Throughput: one beat per cycle while i_stall is low; the input register
// takes a new beat while a finished result waits in the result register.
// Reset: synchronous, active low; clears the safety state, the mode cache
// and both valid flags, and loads the register defaults.
module visual_loss_failsafe_watchdog #(
    parameter int unsigned TIME_BITS = vlfw_pkg::TIME_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [vlfw_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [vlfw_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    // input channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_action,
    input  logic [TIME_BITS-1:0]               i_now_us,
    input  logic                               i_have_mode,
    input  logic                               i_armed,
    input  logic                               i_in_offboard,
    input  logic                               i_landing_mode,
    input  logic                               i_pose_usable,
    input  logic [TIME_BITS-1:0]               i_pose_update_us,
    // result channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_publish_loss,
    output logic                               o_request_land,
    output logic                               o_failsafe_triggered,
    output logic                               o_failsafe_active
);

    localparam int unsigned UB = vlfw_pkg::US_LIMIT_BITS;
    localparam int unsigned DB = vlfw_pkg::CFG_DATA_BITS;

    // configuration, limits kept in microseconds
    logic          r_require_visual;
    logic [UB-1:0] r_pose_age_us;
    logic [UB-1:0] r_loss_timeout_us;
    logic [DB-1:0] w_cfg_clamped;

    // input register
    logic                 r_in_valid;
    logic                 r_in_action;
    logic [TIME_BITS-1:0] r_in_now;
    logic                 r_in_have_mode;
    vlfw_pkg::t_mode_flags r_in_flags;
    logic                 r_in_usable;
    logic [TIME_BITS-1:0] r_in_pu;

    // safety state
    logic                  r_latched,  n_latched;
    logic [TIME_BITS-1:0]  r_loss,     n_loss;
    logic [TIME_BITS-1:0]  r_land,     n_land;
    logic [TIME_BITS-1:0]  r_notice,   n_notice;
    logic                  r_cached,   n_cached;
    vlfw_pkg::t_mode_flags r_flags,    n_flags;

    // result register
    logic r_out_valid;
    logic r_out_notice, n_out_notice;
    logic r_out_land,   n_out_land;
    logic r_out_trig,   n_out_trig;
    logic r_out_active;

    // handshake
    logic w_advance;
    logic w_in_take;

    // decision terms
    logic [TIME_BITS-1:0] w_notice_dt;
    logic [TIME_BITS-1:0] w_land_dt;
    logic [TIME_BITS-1:0] w_pose_age;
    logic [TIME_BITS-1:0] w_start;
    logic [TIME_BITS-1:0] w_loss_dt;
    logic                 w_notice_ok;
    logic                 w_land_ok;
    logic                 w_pose_past;
    logic                 w_pose_fresh;
    logic                 w_timeout;

    // move the input beat on when the result register is free or drains
    assign w_advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !w_advance;
    assign w_in_take = i_valid && !o_stall;

    // clamp a written limit to its floor
    always_comb begin
        w_cfg_clamped = i_cfg_data;
        if (i_cfg_idx == vlfw_pkg::REG_POSE_MAX_AGE_MS) begin
            if (i_cfg_data < DB'(vlfw_pkg::MIN_POSE_AGE_MS)) begin
                w_cfg_clamped = DB'(vlfw_pkg::MIN_POSE_AGE_MS);
            end
        end else if (i_cfg_data < DB'(vlfw_pkg::MIN_LOSS_TIMEOUT_MS)) begin
            w_cfg_clamped = DB'(vlfw_pkg::MIN_LOSS_TIMEOUT_MS);
        end
    end

    // store configuration writes, converting ms to us
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_require_visual  <= 1'b1;
            r_pose_age_us     <= UB'(vlfw_pkg::RST_POSE_AGE_MS * vlfw_pkg::US_PER_MS);
            r_loss_timeout_us <= UB'(vlfw_pkg::RST_LOSS_TIMEOUT_MS * vlfw_pkg::US_PER_MS);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vlfw_pkg::REG_REQUIRE_VISUAL: begin
                    r_require_visual <= i_cfg_data[0];
                end
                vlfw_pkg::REG_POSE_MAX_AGE_MS: begin
                    r_pose_age_us <= UB'(w_cfg_clamped) * UB'(vlfw_pkg::US_PER_MS);
                end
                vlfw_pkg::REG_LOSS_TIMEOUT_MS: begin
                    r_loss_timeout_us <= UB'(w_cfg_clamped) * UB'(vlfw_pkg::US_PER_MS);
                end
                default: begin
                end
            endcase
        end
    end

    // capture the input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_action         <= i_action;
            r_in_now            <= i_now_us;
            r_in_have_mode      <= i_have_mode;
            r_in_flags.armed    <= i_armed;
            r_in_flags.offboard <= i_in_offboard;
            r_in_flags.landing  <= i_landing_mode;
            r_in_usable         <= i_pose_usable;
            r_in_pu             <= i_pose_update_us;
        end
    end

    // rate-limit windows, a stored zero means never
    assign w_notice_dt = r_in_now - r_notice;
    assign w_land_dt   = r_in_now - r_land;
    assign w_notice_ok = (r_notice == '0) ||
                         (w_notice_dt >= TIME_BITS'(vlfw_pkg::NOTICE_GAP_US));
    assign w_land_ok   = (r_land == '0) ||
                         (w_land_dt >= TIME_BITS'(vlfw_pkg::LAND_GAP_US));

    // pose freshness and loss duration
    assign w_pose_past  = r_in_usable && (r_in_pu != '0) && (r_in_pu <= r_in_now);
    assign w_pose_age   = r_in_now - r_in_pu;
    assign w_pose_fresh = w_pose_past && (w_pose_age <= TIME_BITS'(r_pose_age_us));
    assign w_start      = w_pose_past ? r_in_pu : ((r_loss == '0) ? r_in_now : r_loss);
    assign w_loss_dt    = r_in_now - w_start;
    assign w_timeout    = w_loss_dt >= TIME_BITS'(r_loss_timeout_us);

    // safety decision for the beat in the input register
    always_comb begin
        n_latched    = r_latched;
        n_loss       = r_loss;
        n_land       = r_land;
        n_notice     = r_notice;
        n_cached     = r_cached;
        n_flags      = r_flags;
        n_out_notice = 1'b0;
        n_out_land   = 1'b0;
        n_out_trig   = 1'b0;

        if (r_in_action) begin
            // reset action: drop the safety state, keep the mode cache
            n_loss    = '0;
            n_land    = '0;
            n_notice  = '0;
            n_latched = 1'b0;
        end else begin
            if (r_in_have_mode) begin
                n_flags  = r_in_flags;
                n_cached = 1'b1;
            end
            if (n_cached) begin
                if (r_latched) begin
                    // latched: notice, then land retry or clear on disarm
                    if (w_notice_ok) begin
                        n_notice     = r_in_now;
                        n_out_notice = 1'b1;
                    end
                    if (!n_flags.armed) begin
                        n_loss    = '0;
                        n_land    = '0;
                        n_notice  = '0;
                        n_latched = 1'b0;
                    end else if (!n_flags.landing && w_land_ok) begin
                        n_land     = r_in_now;
                        n_out_land = 1'b1;
                    end
                end else if (!(r_require_visual && n_flags.armed && n_flags.offboard)) begin
                    n_loss = '0;
                end else if (w_pose_fresh) begin
                    n_loss = '0;
                end else begin
                    // pose lost: notice, track loss start, check timeout
                    if (w_notice_ok) begin
                        n_notice     = r_in_now;
                        n_out_notice = 1'b1;
                    end
                    n_loss = w_start;
                    if (w_timeout) begin
                        n_latched  = 1'b1;
                        n_out_trig = 1'b1;
                        if (!n_flags.landing && w_land_ok) begin
                            n_land     = r_in_now;
                            n_out_land = 1'b1;
                        end
                    end
                end
            end else if (r_latched && w_land_ok) begin
                // no mode ever seen: retry land as if armed and not landing
                n_land     = r_in_now;
                n_out_land = 1'b1;
            end
        end
    end

    // update state and the result register as the beat advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched   <= 1'b0;
            r_loss      <= '0;
            r_land      <= '0;
            r_notice    <= '0;
            r_cached    <= 1'b0;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_latched   <= n_latched;
                r_loss      <= n_loss;
                r_land      <= n_land;
                r_notice    <= n_notice;
                r_cached    <= n_cached;
                r_flags     <= n_flags;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_notice <= n_out_notice;
            r_out_land   <= n_out_land;
            r_out_trig   <= n_out_trig;
            r_out_active <= n_latched;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_publish_loss       = r_out_notice;
    assign o_request_land       = r_out_land;
    assign o_failsafe_triggered = r_out_trig;
    assign o_failsafe_active    = r_out_active;

endmodule

>>> src/vlfw_checker.sv
// ----------------------------------------------------------------------------
// vlfw_checker
// Port-level checks for the visual-loss failsafe watchdog.
// ----------------------------------------------------------------------------
module vlfw_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_stall,
    input logic o_publish_loss,
    input logic o_request_land,
    input logic o_failsafe_triggered,
    input logic o_failsafe_active
);

    // a triggering beat always reports the latch set
    a_trig_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_failsafe_triggered || o_failsafe_active))
        else $error("failsafe triggered without active latch");

    // a land request is only issued while the latch is held
    a_land_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_request_land || o_failsafe_active))
        else $error("land requested with failsafe inactive");

    // no result beat right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_publish_loss) &&
            $stable(o_request_land) && $stable(o_failsafe_triggered) &&
            $stable(o_failsafe_active)))
        else $error("stalled result beat changed");

endmodule

bind visual_loss_failsafe_watchdog vlfw_checker u_vlfw_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_valid              (o_valid),
    .i_stall              (i_stall),
    .o_publish_loss       (o_publish_loss),
    .o_request_land       (o_request_land),
    .o_failsafe_triggered (o_failsafe_triggered),
    .o_failsafe_active    (o_failsafe_active)
);
